// ----- design/bracket_pair_matcher_core_macros.svh -----
// assertion macros for the bracket pair matcher core
// expects clk and rst in the scope where a macro is used
`ifndef BRACKET_PAIR_MATCHER_CORE_MACROS_SVH
`define BRACKET_PAIR_MATCHER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bpm_pkg.sv -----
// shared types, constants and the character decoder for the bracket matcher
// no dependencies
package bpm_pkg;

  // sizing
  localparam int STACK_DEPTH = 64;
  localparam int MAX_LEN     = 65536;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int POS_W       = $clog2(MAX_LEN + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_PAREN   = 2'd0,
    KIND_BRACKET = 2'd1,
    KIND_BRACE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_UNCLOSED = 3'd2,
    ST_FULL     = 3'd3,
    ST_LONG     = 3'd4
  } status_t;

  // input beat
  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic        is_status;
    logic [15:0] open_pos;
    logic [15:0] close_pos;
    status_t     status;
    logic        string_done;
  } out_beat_t;

  // one stack entry
  typedef struct packed {
    kind_t       kind;
    logic [15:0] pos;
  } entry_t;

  // shift control for the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    unique case (ch)
      CH_LPAREN: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CH_LBRACK: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACKET};
      CH_LBRACE: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACE};
      CH_RPAREN: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CH_RBRACK: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACKET};
      CH_RBRACE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACE};
      default:   c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    endcase
    return c;
  endfunction

endpackage

// ----- design/bpm_cell.sv -----
// one stack cell: holds an entry, takes from above on push, from below on pop
// depends on bpm_pkg
module bpm_cell import bpm_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     from_up,
  input  entry_t     from_down,
  output entry_t     held
);

  // payload shifts, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      held <= from_up;
    end else if (ctrl.pop) begin
      held <= from_down;
    end
  end

endmodule

// ----- design/bpm_out_fifo.sv -----
// small result queue, takes up to two beats a cycle and gives one while out_ready is high
// depends on bpm_pkg
module bpm_out_fifo import bpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr0,
  input  out_beat_t wr0_data,
  input  logic      wr1,
  input  out_beat_t wr1_data,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  out_beat_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr;
  logic [FIFO_AW-1:0]   rptr;
  logic [FIFO_CW-1:0]   count;
  logic [FIFO_CW-1:0]   count_next;
  logic                 rd;

  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign rd        = out_valid & out_ready;
  // room for the worst case of two results from one character
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  assign count_next = count + FIFO_CW'(wr0) + FIFO_CW'(wr1) - FIFO_CW'(rd);

  // storage
  always_ff @(posedge clk) begin
    if (wr0) begin
      mem[wptr] <= wr0_data;
    end
    if (wr1) begin
      mem[wptr + FIFO_AW'(1)] <= wr1_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + FIFO_AW'(wr0) + FIFO_AW'(wr1);
      rptr  <= rptr + FIFO_AW'(rd);
      count <= count_next;
    end
  end

endmodule

// ----- design/bracket_pair_matcher_core.sv -----
// bracket pair matcher core: stack as a chain of shifting cells, result queue
// results: the results of an accepted character are written into the result queue
// throughput: one character per cycle while the result queue has room; a character that
// gives a pair and the final status yields two results, absorbed by the 4-deep result queue
// reset: synchronous rst clears stack level, position, error flag and queue
// depends on bpm_pkg, bpm_cell, bpm_out_fifo and the assertion macro header
`include "bracket_pair_matcher_core_macros.svh"
module bracket_pair_matcher_core import bpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic [LVL_W-1:0] stack_level;
  logic [LVL_W-1:0] stack_level_next;
  logic [POS_W-1:0] char_pos;
  logic             error_seen;

  logic             acc;
  char_class_t      cls;
  logic             too_long;
  logic             full;
  logic             match;
  logic             push;
  logic             pop;
  status_t          err;
  logic             emit0;
  logic             emit1;
  out_beat_t        beat0;
  out_beat_t        beat1;
  out_beat_t        pair_beat;
  out_beat_t        status_beat;
  logic [15:0]      pos16;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           held [STACK_DEPTH];
  logic             last_acc;
  logic             string_idle;

  assign acc   = in_valid & in_ready;
  assign cls   = classify(in_data.ch);
  assign pos16 = 16'(char_pos);

  // classify the character against the top cell
  assign too_long = (char_pos >= POS_W'(MAX_LEN));
  assign full     = (stack_level == LVL_W'(STACK_DEPTH));
  assign match    = cls.is_close && (stack_level != '0) && (held[0].kind == cls.kind);

  always_comb begin
    if (too_long) begin
      err = ST_LONG;
    end else if (cls.is_open) begin
      err = full ? ST_FULL : ST_OK;
    end else if (match) begin
      err = ST_OK;
    end else begin
      err = ST_MISMATCH;
    end
  end

  assign push = !error_seen && !too_long && cls.is_open && !full;
  assign pop  = !error_seen && !too_long && match;

  always_comb begin
    stack_level_next = stack_level;
    if (push) begin
      stack_level_next = stack_level + LVL_W'(1);
    end else if (pop) begin
      stack_level_next = stack_level - LVL_W'(1);
    end
  end

  // result beats
  always_comb begin
    pair_beat = '{is_status: 1'b0, open_pos: held[0].pos, close_pos: pos16,
                  status: ST_OK, string_done: 1'b0};
    status_beat = '{is_status: 1'b1, open_pos: 16'd0, close_pos: 16'd0,
                    status: ST_OK, string_done: 1'b1};
    if (err != ST_OK) begin
      status_beat.status = err;
    end else if (stack_level_next != '0) begin
      status_beat.status = ST_UNCLOSED;
    end
  end

  always_comb begin
    emit0 = 1'b0;
    emit1 = 1'b0;
    beat0 = status_beat;
    beat1 = status_beat;
    if (acc && !error_seen) begin
      if (pop) begin
        emit0 = 1'b1;
        beat0 = pair_beat;
        emit1 = in_data.last_char;
      end else if (err != ST_OK || in_data.last_char) begin
        emit0 = 1'b1;
      end
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_level <= '0;
      char_pos    <= '0;
      error_seen  <= 1'b0;
    end else if (acc) begin
      if (in_data.last_char) begin
        stack_level <= '0;
        char_pos    <= '0;
        error_seen  <= 1'b0;
      end else if (!error_seen) begin
        stack_level <= stack_level_next;
        if (!too_long) begin
          char_pos <= char_pos + POS_W'(1);
        end
        if (err != ST_OK) begin
          error_seen <= 1'b1;
        end
      end
    end
  end

  // cell chain, cell 0 is the top of stack
  assign ctrl      = '{push: acc && push, pop: acc && pop};
  assign new_entry = '{kind: cls.kind, pos: pos16};

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t up_in;
    entry_t down_in;
    if (i == 0) begin : g_top
      assign up_in = new_entry;
    end else begin : g_mid
      assign up_in = held[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_in = held[i];
    end else begin : g_inner
      assign down_in = held[i+1];
    end
    bpm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_up   (up_in),
      .from_down (down_in),
      .held      (held[i])
    );
  end

  // result queue
  bpm_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr0       (emit0),
    .wr0_data  (beat0),
    .wr1       (emit1),
    .wr1_data  (beat1),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  assign last_acc    = acc & in_data.last_char;
  assign string_idle = (stack_level == '0) && (char_pos == '0) && !error_seen;

  `BPM_ASSERT_NOW(a_level_range, 1'b1, stack_level <= LVL_W'(STACK_DEPTH), "stack level overrun")
  `BPM_ASSERT_NOW(a_push_pop_excl, 1'b1, !(push && pop), "push and pop together")
  `BPM_ASSERT_NEXT(a_result_shows, emit0, out_valid, "emitted result not presented")
  `BPM_ASSERT_NEXT(a_clear_on_last, last_acc, string_idle, "string state not cleared")

endmodule

// ----- tb/sv/tb.sv -----
// testbench for bracket_pair_matcher_core: directed and random strings against a
// built-in stack predictor, with random idling on both valid/ready channels
// depends on bpm_pkg and the core rtl
module tb;
  import bpm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 12;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // input beats waiting to be driven, results waiting to be seen
  in_beat_t  pending_chars[$];
  out_beat_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // predictor copy of the string state
  kind_t       bracket_kind[STACK_DEPTH];
  logic [15:0] bracket_pos[STACK_DEPTH];
  int unsigned depth_now = 0;
  int unsigned next_pos = 0;
  bit          string_failed = 1'b0;

  bracket_pair_matcher_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] open_char(kind_t k);
    case (k)
      KIND_PAREN:   return CH_LPAREN;
      KIND_BRACKET: return CH_LBRACK;
      default:      return CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(kind_t k);
    case (k)
      KIND_PAREN:   return CH_RPAREN;
      KIND_BRACKET: return CH_RBRACK;
      default:      return CH_RBRACE;
    endcase
  endfunction

  function void push_result(logic is_stat, logic [15:0] op, logic [15:0] cp,
                            status_t code, logic done);
    out_beat_t r;
    r.is_status   = is_stat;
    r.open_pos    = op;
    r.close_pos   = cp;
    r.status      = code;
    r.string_done = done;
    expected_results.push_back(r);
  endfunction

  function void clear_string_state();
    depth_now     = 0;
    next_pos      = 0;
    string_failed = 1'b0;
  endfunction

  // works out the results of one accepted character
  function void match_char(in_beat_t b);
    int unsigned pos;
    bit          is_open;
    bit          is_close;
    kind_t       k;
    status_t     err;
    pos      = next_pos;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_PAREN;
    err      = ST_OK;
    // rest of a failed string is dropped
    if (string_failed) begin
      if (b.last_char)
        clear_string_state();
      return;
    end
    if (next_pos < MAX_LEN)
      next_pos++;
    case (b.ch)
      CH_LPAREN: begin is_open = 1'b1; k = KIND_PAREN; end
      CH_LBRACK: begin is_open = 1'b1; k = KIND_BRACKET; end
      CH_LBRACE: begin is_open = 1'b1; k = KIND_BRACE; end
      CH_RPAREN: begin is_close = 1'b1; k = KIND_PAREN; end
      CH_RBRACK: begin is_close = 1'b1; k = KIND_BRACKET; end
      CH_RBRACE: begin is_close = 1'b1; k = KIND_BRACE; end
      default: ;
    endcase
    if (pos >= MAX_LEN) begin
      err = ST_LONG;
    end else if (is_open) begin
      if (depth_now >= STACK_DEPTH) begin
        err = ST_FULL;
      end else begin
        bracket_kind[depth_now] = k;
        bracket_pos[depth_now]  = pos[15:0];
        depth_now++;
      end
    end else if (is_close && depth_now > 0 && bracket_kind[depth_now-1] == k) begin
      depth_now--;
      push_result(1'b0, bracket_pos[depth_now], pos[15:0], ST_OK, 1'b0);
    end else begin
      err = ST_MISMATCH;
    end
    if (err != ST_OK) begin
      push_result(1'b1, '0, '0, err, 1'b1);
      string_failed = 1'b1;
      if (b.last_char)
        clear_string_state();
      return;
    end
    if (b.last_char) begin
      push_result(1'b1, '0, '0, (depth_now == 0) ? ST_OK : ST_UNCLOSED, 1'b1);
      clear_string_state();
    end
  endfunction

  // compares one result beat with the oldest expectation
  task automatic check_result(out_beat_t got);
    out_beat_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result beat %p", got);
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.is_status !== want.is_status) begin
      $error("is_status: expected %0d, got %0d", want.is_status, got.is_status);
      mismatch_count++;
    end
    if (got.open_pos !== want.open_pos) begin
      $error("open_pos: expected %0d, got %0d", want.open_pos, got.open_pos);
      mismatch_count++;
    end
    if (got.close_pos !== want.close_pos) begin
      $error("close_pos: expected %0d, got %0d", want.close_pos, got.close_pos);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.string_done !== want.string_done) begin
      $error("string_done: expected %0d, got %0d", want.string_done, got.string_done);
      mismatch_count++;
    end
  endtask

  // driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        match_char(in_data);
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_chars.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks accepted results and stalls at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_char(logic [7:0] c, logic last);
    in_beat_t b;
    b.ch        = c;
    b.last_char = last;
    pending_chars.push_back(b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i], i == s.len() - 1);
  endtask

  // one random string: mostly well-formed, some deep, unclosed, broken or noise
  task automatic queue_random_string(output int n_added);
    logic [7:0] text[$];
    kind_t      opened[$];
    kind_t      k;
    int         mode;
    int         len;
    int         spot;
    mode = $urandom_range(99);
    len  = $urandom_range(1, 24);
    if (mode < 6) begin
      // deep nesting around the stack limit
      len = $urandom_range(56, 66);
      for (int i = 0; i < len; i++) begin
        k = kind_t'($urandom_range(2));
        opened.push_back(k);
        text.push_back(open_char(k));
      end
      while (opened.size() != 0)
        text.push_back(close_char(opened.pop_back()));
    end else if (mode < 16) begin
      // noise bytes with some brackets mixed in
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(1))
          text.push_back(8'($urandom_range(255)));
        else if ($urandom_range(1))
          text.push_back(open_char(kind_t'($urandom_range(2))));
        else
          text.push_back(close_char(kind_t'($urandom_range(2))));
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        if (opened.size() == 0 || $urandom_range(1)) begin
          k = kind_t'($urandom_range(2));
          opened.push_back(k);
          text.push_back(open_char(k));
        end else begin
          text.push_back(close_char(opened.pop_back()));
        end
      end
      // leave some strings unclosed
      if (mode >= 26) begin
        while (opened.size() != 0)
          text.push_back(close_char(opened.pop_back()));
      end
      // break a few well-formed strings at one spot
      if (mode >= 86) begin
        spot = $urandom_range(text.size() - 1);
        case ($urandom_range(2))
          0: text[spot] = 8'($urandom_range(255));
          1: text[spot] = close_char(kind_t'($urandom_range(2)));
          default: text.insert(spot, close_char(kind_t'($urandom_range(2))));
        endcase
      end
    end
    foreach (text[i])
      add_char(text[i], i == text.size() - 1);
    n_added = text.size();
  endtask

  task automatic queue_random_chars(int n_items);
    int total;
    int n;
    total = 0;
    while (total < n_items) begin
      queue_random_string(n);
      total += n;
    end
  endtask

  // holds off until every beat is sent and every result has come back
  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n_items);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_chars(n_items);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed strings, no idling
    add_text("([{}])");
    add_text(")");
    add_text("(");
    add_text("(]xy)");
    add_text("{[)");
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b1);
    add_text("()[]{}");
    add_text("a(");
    wait_idle();

    // full stack, then a full-depth string that closes cleanly
    for (int i = 0; i < STACK_DEPTH; i++)
      add_char(CH_LBRACE, 1'b0);
    add_char(CH_LPAREN, 1'b0);
    add_char(CH_RBRACK, 1'b1);
    for (int i = 0; i < STACK_DEPTH; i++)
      add_char(CH_LBRACK, 1'b0);
    for (int i = 0; i < STACK_DEPTH; i++)
      add_char(CH_RBRACK, i == STACK_DEPTH - 1);

    // overlong string: pairs up to the last legal position, then too long
    for (int i = 0; i < MAX_LEN / 2; i++) begin
      add_char(CH_LPAREN, 1'b0);
      add_char(CH_RPAREN, 1'b0);
    end
    add_char(CH_LPAREN, 1'b0);
    add_char(8'h61, 1'b0);
    add_char(CH_RPAREN, 1'b1);
    wait_idle();

    run_phase(0, 0, 250);
    run_phase(50, 0, 250);
    run_phase(0, 50, 250);
    run_phase(29, 29, 250);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
